[design/assert_macros.svh]
// Assertion macros used by the checker module.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define SFQ_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sfq check failed");
// next-cycle implication
`define SFQ_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sfq check failed");
`endif

[design/sfq_pkg.sv]
// Shared types, codes and constants of the SFQ/DRR packet scheduler.
// No dependencies; sfq_front, sfq_back, the top level, the checker and the testbench use it.
`default_nettype none
package sfq_pkg;

	localparam int MAX_FLOWS_DEF    = 1024;
	localparam int BUFFER_SLOTS_DEF = 1024;

	localparam int CNT_W  = 11;   // packet counts, limits
	localparam int DEF_W  = 18;   // signed deficit
	localparam int FIDX_W = 11;   // flow index field of a result
	localparam int HASH_W = 32;

	// hash reduction: bits retired per divider cycle
	localparam int DIV_BITS   = 4;
	localparam int DIV_STEPS  = HASH_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [2:0] ST_ACCEPTED   = 3'd0;
	localparam logic [2:0] ST_DROP_LIMIT = 3'd1;
	localparam logic [2:0] ST_DROP_FULL  = 3'd2;
	localparam logic [2:0] ST_DEQUEUED   = 3'd3;
	localparam logic [2:0] ST_EMPTY      = 3'd4;

	localparam logic [2:0] CFG_QUANTUM     = 3'd0;
	localparam logic [2:0] CFG_TOTAL_LIMIT = 3'd1;
	localparam logic [2:0] CFG_FLOW_LIMIT  = 3'd2;
	localparam logic [2:0] CFG_FLOWS       = 3'd3;
	localparam logic [2:0] CFG_FAIR_SHARE  = 3'd4;
	localparam logic [2:0] CFG_NS2_MODE    = 3'd5;

	typedef struct packed {
		logic              cmd;
		logic [31:0]       flow_hash;
		logic              unclassified;
		logic [15:0]       packet_size;
		logic [15:0]       packet_handle;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [FIDX_W-1:0] flow_index;
		logic [15:0]       out_size;
		logic [15:0]       out_handle;
	} result_t;

	typedef struct packed {
		logic [15:0]      quantum;
		logic [CNT_W-1:0] total_limit;
		logic [CNT_W-1:0] per_flow_limit;
		logic [CNT_W-1:0] flows_in_use;
		logic [CNT_W-1:0] fair_share;
		logic             ns2_mode;
	} cfg_t;

endpackage
`default_nettype wire

[design/sfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[design/sfq_front.sv]
// Front end: takes commands, reduces the flow hash to a flow index.
// Uses sfq_pkg; feeds the command queue.
`default_nettype none
module sfq_front #(
	parameter int MAX_FLOWS = sfq_pkg::MAX_FLOWS_DEF,
	localparam int FIW = $clog2(MAX_FLOWS + 1),
	localparam int EW  = 1 + FIW + 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sfq_pkg::in_item_t item,
	input  wire logic [FIW-1:0]    nf,
	input  wire logic              hold,
	output logic                   busy,
	output logic                   push,
	output logic [EW-1:0]          entry
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t                         state_q;
	logic [sfq_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [31:0]                     hash_q;
	logic [FIW-1:0]                  rem_q;
	logic [FIW-1:0]                  rem_nxt;
	logic [FIW:0]                    trial;
	logic [31:0]                     hsh;
	logic                            cmd_q;
	logic [15:0]                     size_q;
	logic [15:0]                     handle_q;
	logic                            accept;

	assign busy   = (state_q != F_IDLE) || hold;
	assign accept = start && !busy;
	assign push   = (state_q == F_PUSH);
	assign entry  = {cmd_q, rem_q, size_q, handle_q};

	// restoring remainder, DIV_BITS hash bits per cycle
	always_comb begin
		rem_nxt = rem_q;
		hsh     = hash_q;
		trial   = '0;
		for (int k = 0; k < sfq_pkg::DIV_BITS; k++) begin
			trial = {rem_nxt, hsh[31]};
			hsh   = {hsh[30:0], 1'b0};
			if (trial >= {1'b0, nf}) begin
				trial = trial - {1'b0, nf};
			end
			rem_nxt = trial[FIW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (item.cmd == sfq_pkg::CMD_ENQ && !item.unclassified) begin
							state_q <= F_DIV;
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == sfq_pkg::DIV_CNT_W'(sfq_pkg::DIV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			cmd_q    <= item.cmd;
			size_q   <= item.packet_size;
			handle_q <= item.packet_handle;
			hash_q   <= item.flow_hash;
			// unclassified packets go to the extra flow, dequeues need no flow
			if (item.cmd == sfq_pkg::CMD_ENQ && item.unclassified) begin
				rem_q <= nf;
			end else begin
				rem_q <= '0;
			end
		end else if (state_q == F_DIV) begin
			hash_q <= hash_q << sfq_pkg::DIV_BITS;
			rem_q  <= rem_nxt;
		end
	end
endmodule
`default_nettype wire

[design/sfq_queue.sv]
// Two-entry command queue between the front end and the scheduler core.
// No package dependencies.
`default_nettype none
module sfq_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic                  valid,
	output logic                  full,
	output logic [WIDTH-1:0]      dout
);
	logic [1:0]       cnt_q;
	logic [WIDTH-1:0] data0_q;
	logic [WIDTH-1:0] data1_q;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = data0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data0_q <= (push && cnt_q == 2'd1) ? din : data1_q;
			if (push && cnt_q == 2'd2) begin
				data1_q <= din;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				data0_q <= din;
			end else begin
				data1_q <= din;
			end
		end
	end
endmodule
`default_nettype wire

[design/sfq_back.sv]
// Scheduler core: admission, per-flow packet lists, active ring, DRR service.
// Uses sfq_pkg and sfq_ram; takes commands from sfq_queue.
`default_nettype none
module sfq_back #(
	parameter int MAX_FLOWS    = sfq_pkg::MAX_FLOWS_DEF,
	parameter int BUFFER_SLOTS = sfq_pkg::BUFFER_SLOTS_DEF,
	localparam int FIW = $clog2(MAX_FLOWS + 1),
	localparam int EW  = 1 + FIW + 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfq_pkg::cfg_t     cfg,
	input  wire logic [FIW-1:0]    nf,
	input  wire logic [15:0]       eff_q,
	input  wire logic              q_valid,
	input  wire logic [EW-1:0]     q_entry,
	output logic                   q_pop,
	output logic                   ready,
	output logic                   result_valid,
	output sfq_pkg::result_t       result
);
	localparam int NFLOW    = MAX_FLOWS + 1;
	localparam int SW       = $clog2(BUFFER_SLOTS);
	localparam int FCW      = $clog2(BUFFER_SLOTS + 1);
	localparam int RCW      = $clog2(NFLOW + 1);
	localparam int INIT_LEN = (NFLOW > BUFFER_SLOTS) ? NFLOW : BUFFER_SLOTS;
	localparam int IW       = $clog2(INIT_LEN);
	localparam int CNT_W    = sfq_pkg::CNT_W;
	localparam int DEF_W    = sfq_pkg::DEF_W;
	localparam int OFW      = sfq_pkg::FIDX_W;
	localparam int AW       = (FIW > CNT_W) ? FIW : CNT_W;

	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic signed [DEF_W-1:0] deficit;
		logic                    active;
		logic [SW-1:0]           head;
		logic [SW-1:0]           tail;
	} flow_rec_t;
	localparam int RECW = $bits(flow_rec_t);

	typedef enum logic [7:0] {
		B_INIT = 8'b00000001,
		B_IDLE = 8'b00000010,
		B_EN1  = 8'b00000100,
		B_EN2  = 8'b00001000,
		B_DQ0  = 8'b00010000,
		B_DQ1  = 8'b00100000,
		B_DQ2  = 8'b01000000,
		B_DQ3  = 8'b10000000
	} bstate_t;

	bstate_t          state_q, state_d;
	logic [IW-1:0]    init_q, init_d;
	logic [FCW-1:0]   free_q, free_d;
	logic [CNT_W-1:0] total_q, total_d;
	logic [FIW-1:0]   rhead_q, rhead_d;
	logic [FIW-1:0]   rtail_q, rtail_d;
	logic [RCW-1:0]   rcnt_q, rcnt_d;
	logic             rv_q, rv_d;
	sfq_pkg::result_t res_q, res_d;

	logic [FIW-1:0]   op_flow_q;
	logic [15:0]      op_size_q;
	logic [15:0]      op_handle_q;
	logic [FIW-1:0]   f_q, f_d;
	flow_rec_t        rec_q, rec_d;

	logic             flow_we;
	logic [FIW-1:0]   flow_waddr, flow_raddr;
	flow_rec_t        flow_wdata, flow_rdata;
	logic             ring_we;
	logic [FIW-1:0]   ring_waddr, ring_raddr, ring_wdata, ring_rdata;
	logic             data_we;
	logic [SW-1:0]    data_waddr, data_raddr;
	logic [31:0]      data_wdata, data_rdata;
	logic             next_we;
	logic [SW-1:0]    next_waddr, next_raddr, next_wdata, next_rdata;
	logic             stk_we;
	logic [SW-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	flow_rec_t        nrec;
	logic [CNT_W-1:0] left;
	logic             left_lt_nf;
	logic             drop;

	function automatic logic [FIW-1:0] ring_inc(input logic [FIW-1:0] p);
		return (p == FIW'(NFLOW - 1)) ? '0 : p + 1'b1;
	endfunction

	assign q_pop        = (state_q == B_IDLE) && q_valid;
	assign ready        = (state_q != B_INIT);
	assign result_valid = rv_q;
	assign result       = res_q;

	// admission
	always_comb begin
		left       = (cfg.total_limit > total_q) ? cfg.total_limit - total_q : '0;
		left_lt_nf = AW'(left) < AW'(nf);
		if (cfg.ns2_mode) begin
			drop = (flow_rdata.count >= (left >> 1)) ||
			       (left_lt_nf && flow_rdata.count > cfg.fair_share) || (left == '0);
		end else begin
			drop = (total_q >= cfg.total_limit) ||
			       (left_lt_nf && flow_rdata.count > cfg.fair_share);
		end
	end

	always_comb begin
		flow_we    = 1'b0;
		flow_waddr = op_flow_q;
		flow_raddr = op_flow_q;
		flow_wdata = '0;
		ring_we    = 1'b0;
		ring_waddr = rtail_q;
		ring_wdata = op_flow_q;
		ring_raddr = rhead_q;
		data_we    = 1'b0;
		data_waddr = stk_rdata;
		data_wdata = {op_size_q, op_handle_q};
		data_raddr = flow_rdata.head;
		next_we    = 1'b0;
		next_waddr = flow_rdata.tail;
		next_wdata = stk_rdata;
		next_raddr = flow_rdata.head;
		stk_we     = 1'b0;
		stk_waddr  = free_q[SW-1:0];
		stk_wdata  = rec_q.head;
		stk_raddr  = SW'(free_q - 1'b1);
		nrec       = flow_rdata;

		state_d = state_q;
		init_d  = init_q;
		free_d  = free_q;
		total_d = total_q;
		rhead_d = rhead_q;
		rtail_d = rtail_q;
		rcnt_d  = rcnt_q;
		rv_d    = 1'b0;
		res_d   = res_q;
		f_d     = f_q;
		rec_d   = rec_q;

		unique case (state_q)
			B_INIT: begin
				// clear flow records, lay out the free stack
				flow_waddr = init_q[FIW-1:0];
				flow_we    = {1'b0, init_q} < (IW + 1)'(NFLOW);
				stk_waddr  = init_q[SW-1:0];
				stk_wdata  = SW'(BUFFER_SLOTS - 1) - init_q[SW-1:0];
				stk_we     = {1'b0, init_q} < (IW + 1)'(BUFFER_SLOTS);
				init_d     = init_q + 1'b1;
				if (init_q == IW'(INIT_LEN - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (q_valid) begin
					state_d = (q_entry[EW-1] == sfq_pkg::CMD_DEQ) ? B_DQ0 : B_EN1;
				end
			end
			B_EN1: begin
				state_d = B_EN2;
			end
			B_EN2: begin
				state_d = B_IDLE;
				rv_d    = 1'b1;
				res_d   = '{status: sfq_pkg::ST_ACCEPTED, flow_index: OFW'(op_flow_q),
				            out_size: '0, out_handle: '0};
				if (drop || free_q == '0) begin
					res_d.status = sfq_pkg::ST_DROP_LIMIT;
				end else if (flow_rdata.count >= cfg.per_flow_limit) begin
					res_d.status = sfq_pkg::ST_DROP_FULL;
				end else begin
					if (!flow_rdata.active) begin
						nrec.active = 1'b1;
						if (!cfg.ns2_mode) begin
							nrec.deficit = $signed({{(DEF_W - 16){1'b0}}, eff_q});
						end
						ring_we = 1'b1;
						rtail_d = ring_inc(rtail_q);
						rcnt_d  = rcnt_q + 1'b1;
					end
					data_we = 1'b1;
					next_we = (flow_rdata.count != '0);
					if (flow_rdata.count == '0) begin
						nrec.head = stk_rdata;
					end
					nrec.tail  = stk_rdata;
					nrec.count = flow_rdata.count + 1'b1;
					flow_we    = 1'b1;
					flow_wdata = nrec;
					free_d     = free_q - 1'b1;
					total_d    = total_q + 1'b1;
				end
			end
			B_DQ0: begin
				if (rcnt_q == '0) begin
					state_d = B_IDLE;
					rv_d    = 1'b1;
					res_d   = '{status: sfq_pkg::ST_EMPTY, flow_index: '0,
					            out_size: '0, out_handle: '0};
				end else begin
					state_d = B_DQ1;
				end
			end
			B_DQ1: begin
				flow_raddr = ring_rdata;
				f_d        = ring_rdata;
				state_d    = B_DQ2;
			end
			B_DQ2: begin
				rec_d      = flow_rdata;
				flow_waddr = f_q;
				ring_wdata = f_q;
				if (!cfg.ns2_mode &&
				    (flow_rdata.deficit[DEF_W-1] || flow_rdata.deficit == '0)) begin
					// top up and rotate to the back
					nrec.deficit = flow_rdata.deficit + $signed({{(DEF_W - 16){1'b0}}, eff_q});
					flow_we      = 1'b1;
					flow_wdata   = nrec;
					ring_we      = 1'b1;
					rhead_d      = ring_inc(rhead_q);
					rtail_d      = ring_inc(rtail_q);
					state_d      = B_DQ0;
				end else if (flow_rdata.count == '0) begin
					// drop the empty flow from the ring
					nrec.active = 1'b0;
					flow_we     = 1'b1;
					flow_wdata  = nrec;
					rhead_d     = ring_inc(rhead_q);
					rcnt_d      = rcnt_q - 1'b1;
					state_d     = B_DQ0;
				end else begin
					state_d = B_DQ3;
				end
			end
			B_DQ3: begin
				nrec       = rec_q;
				nrec.count = rec_q.count - 1'b1;
				nrec.head  = next_rdata;
				flow_waddr = f_q;
				ring_wdata = f_q;
				stk_we     = 1'b1;
				free_d     = free_q + 1'b1;
				total_d    = total_q - 1'b1;
				if (cfg.ns2_mode) begin
					rhead_d = ring_inc(rhead_q);
					if (rec_q.count == CNT_W'(1)) begin
						nrec.active = 1'b0;
						rcnt_d      = rcnt_q - 1'b1;
					end else begin
						ring_we = 1'b1;
						rtail_d = ring_inc(rtail_q);
					end
				end else begin
					nrec.deficit = rec_q.deficit -
					               $signed({{(DEF_W - 16){1'b0}}, data_rdata[31:16]});
				end
				flow_we    = 1'b1;
				flow_wdata = nrec;
				rv_d       = 1'b1;
				res_d      = '{status: sfq_pkg::ST_DEQUEUED, flow_index: OFW'(f_q),
				               out_size: data_rdata[31:16], out_handle: data_rdata[15:0]};
				state_d    = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			init_q  <= '0;
			free_q  <= FCW'(BUFFER_SLOTS);
			total_q <= '0;
			rhead_q <= '0;
			rtail_q <= '0;
			rcnt_q  <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
			free_q  <= free_d;
			total_q <= total_d;
			rhead_q <= rhead_d;
			rtail_q <= rtail_d;
			rcnt_q  <= rcnt_d;
			rv_q    <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		f_q   <= f_d;
		rec_q <= rec_d;
		if (q_pop) begin
			op_flow_q   <= q_entry[EW-2 -: FIW];
			op_size_q   <= q_entry[31:16];
			op_handle_q <= q_entry[15:0];
		end
	end

	sfq_ram #(.WIDTH(RECW), .DEPTH(NFLOW)) u_flow_ram (
		.clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
		.raddr(flow_raddr), .rdata(flow_rdata)
	);
	sfq_ram #(.WIDTH(FIW), .DEPTH(NFLOW)) u_ring_ram (
		.clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
		.raddr(ring_raddr), .rdata(ring_rdata)
	);
	sfq_ram #(.WIDTH(32), .DEPTH(BUFFER_SLOTS)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
		.raddr(data_raddr), .rdata(data_rdata)
	);
	sfq_ram #(.WIDTH(SW), .DEPTH(BUFFER_SLOTS)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(next_raddr), .rdata(next_rdata)
	);
	sfq_ram #(.WIDTH(SW), .DEPTH(BUFFER_SLOTS)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);
endmodule
`default_nettype wire

[design/sfq_drr_packet_scheduler_top.sv]
// Top level of the SFQ/DRR packet scheduler: config registers, front end,
// command queue and scheduler core. Depends on sfq_pkg, sfq_front, sfq_queue, sfq_back.
//
//  channel  | direction | handshake                 | payload
//  command  | in        | start / busy              | item   (sfq_pkg::in_item_t)
//  result   | out       | result_valid strobe       | result (sfq_pkg::result_t)
//  config   | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// After reset a clearing pass over the flow records and the free stack holds busy high.
// A hashed enqueue passes through the front divider before it is queued, others go to
// the queue directly; the core takes an enqueue through B_EN1 and B_EN2 and a dequeue
// through B_DQ0 to B_DQ3 (back to idle from B_DQ0 when the ring is empty), and repeats
// B_DQ0 to B_DQ2 for each flow rotated or removed on the active ring before one can send.
// The two-entry queue lets the front take the next command while the core works.
// Results are a one-cycle strobe; the receiver cannot stall. cfg_ready is always high.
`default_nettype none
module sfq_drr_packet_scheduler_top #(
	parameter int MAX_FLOWS    = sfq_pkg::MAX_FLOWS_DEF,
	parameter int BUFFER_SLOTS = sfq_pkg::BUFFER_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sfq_pkg::in_item_t item,
	output logic                   result_valid,
	output sfq_pkg::result_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	localparam int FIW   = $clog2(MAX_FLOWS + 1);
	localparam int EW    = 1 + FIW + 32;
	localparam int CNT_W = sfq_pkg::CNT_W;
	localparam int XW    = (FIW > CNT_W) ? FIW : CNT_W;

	sfq_pkg::cfg_t  cfg_q;
	logic [FIW-1:0] nf;
	logic [15:0]    eff_q;
	logic [XW-1:0]  flows_x;
	logic           q_push, q_pop, q_valid, q_full, core_ready;
	logic [EW-1:0]  q_din, q_dout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{quantum: 16'd1500, total_limit: CNT_W'(1024),
			           per_flow_limit: CNT_W'(1024), flows_in_use: CNT_W'(1024),
			           fair_share: CNT_W'(1), ns2_mode: 1'b0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfq_pkg::CFG_QUANTUM:     cfg_q.quantum        <= cfg_data;
				sfq_pkg::CFG_TOTAL_LIMIT: cfg_q.total_limit    <= cfg_data[CNT_W-1:0];
				sfq_pkg::CFG_FLOW_LIMIT:  cfg_q.per_flow_limit <= cfg_data[CNT_W-1:0];
				sfq_pkg::CFG_FLOWS:       cfg_q.flows_in_use   <= cfg_data[CNT_W-1:0];
				sfq_pkg::CFG_FAIR_SHARE:  cfg_q.fair_share     <= cfg_data[CNT_W-1:0];
				sfq_pkg::CFG_NS2_MODE:    cfg_q.ns2_mode       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp flows to 1..MAX_FLOWS, quantum to at least 1
	always_comb begin
		flows_x = XW'(cfg_q.flows_in_use);
		if (flows_x == '0) begin
			nf = FIW'(1);
		end else if (flows_x > XW'(MAX_FLOWS)) begin
			nf = FIW'(MAX_FLOWS);
		end else begin
			nf = FIW'(flows_x);
		end
		eff_q = (cfg_q.quantum == '0) ? 16'd1 : cfg_q.quantum;
	end

	sfq_front #(.MAX_FLOWS(MAX_FLOWS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .nf(nf),
		.hold(q_full || !core_ready), .busy(busy), .push(q_push), .entry(q_din)
	);

	sfq_queue #(.WIDTH(EW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_din), .pop(q_pop),
		.valid(q_valid), .full(q_full), .dout(q_dout)
	);

	sfq_back #(.MAX_FLOWS(MAX_FLOWS), .BUFFER_SLOTS(BUFFER_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .nf(nf), .eff_q(eff_q),
		.q_valid(q_valid), .q_entry(q_dout), .q_pop(q_pop), .ready(core_ready),
		.result_valid(result_valid), .result(result)
	);
endmodule
`default_nettype wire

[design/sfq_checker.sv]
// Port-level checker for the SFQ/DRR scheduler top, bound to it below.
// Depends on sfq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sfq_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              result_valid,
	input wire sfq_pkg::result_t  result
);
	logic [2:0] pend_q;

	// track commands taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'((start && !busy) ? 1 : 0) - 3'(result_valid ? 1 : 0);
		end
	end

	`SFQ_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
	`SFQ_ASSERT_IMP(a_result_has_command, result_valid, pend_q != 3'd0)
	`SFQ_ASSERT_IMP(a_status_code, result_valid, result.status == sfq_pkg::ST_ACCEPTED || result.status == sfq_pkg::ST_DROP_LIMIT || result.status == sfq_pkg::ST_DROP_FULL || result.status == sfq_pkg::ST_DEQUEUED || result.status == sfq_pkg::ST_EMPTY)
	`SFQ_ASSERT_IMP(a_no_payload, result_valid && result.status != sfq_pkg::ST_DEQUEUED, result.out_size == 16'd0 && result.out_handle == 16'd0)
endmodule

bind sfq_drr_packet_scheduler_top sfq_checker u_sfq_checker (.*);
`default_nettype wire

[tb/sfq_checker.sv]
// Scoreboard for the SFQ/DRR packet scheduler: watches the command, config and
// result channels, predicts each result and compares it. Depends on sfq_pkg.
module sfq_scoreboard (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  sfq_pkg::in_item_t item,
	input  logic              result_valid,
	input  sfq_pkg::result_t  result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                fail_count,
	output int                pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NF        = sfq_pkg::MAX_FLOWS_DEF + 1;
	localparam int NS        = sfq_pkg::BUFFER_SLOTS_DEF;
	localparam int EXP_DEPTH = 16;

	int unsigned quantum_r, total_lim, flow_lim, flows_r, share_r;
	bit          ns2;

	int unsigned pkt_count [NF];
	int          deficit   [NF];
	bit          active    [NF];
	int unsigned ring      [NF];
	int unsigned ring_head, ring_tail, ring_len;
	int unsigned list_head [NF];
	int unsigned list_tail [NF];
	int unsigned slot_size [NS];
	int unsigned slot_hdl  [NS];
	int unsigned slot_link [NS];
	int unsigned free_slots[NS];
	int unsigned free_len, total_pkts;

	// expected results in order, as a small circular buffer
	sfq_pkg::result_t exp_buf[EXP_DEPTH];
	int unsigned      exp_wr = 0;
	int unsigned      exp_rd = 0;

	assign pending_count = int'(exp_wr - exp_rd);

	function automatic void store_expected(sfq_pkg::result_t r);
		exp_buf[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	function automatic sfq_pkg::result_t take_expected();
		sfq_pkg::result_t r;
		r = exp_buf[exp_rd % EXP_DEPTH];
		exp_rd++;
		return r;
	endfunction

	function automatic int unsigned eff_quantum();
		return quantum_r == 0 ? 1 : quantum_r;
	endfunction

	function automatic int unsigned eff_flows();
		if (flows_r == 0) return 1;
		if (flows_r > sfq_pkg::MAX_FLOWS_DEF) return sfq_pkg::MAX_FLOWS_DEF;
		return flows_r;
	endfunction

	function automatic void ring_push(int unsigned f);
		if (ring_len >= NF) return;
		ring[ring_tail] = f;
		ring_tail = (ring_tail + 1) % NF;
		ring_len++;
	endfunction

	function automatic void ring_pop();
		if (ring_len == 0) return;
		ring_head = (ring_head + 1) % NF;
		ring_len--;
	endfunction

	function automatic void clear_state();
		quantum_r = 1500; total_lim = 1024; flow_lim = 1024;
		flows_r = 1024; share_r = 1; ns2 = 0;
		for (int i = 0; i < NF; i++) begin
			pkt_count[i] = 0; deficit[i] = 0; active[i] = 0;
			ring[i] = 0; list_head[i] = 0; list_tail[i] = 0;
		end
		for (int i = 0; i < NS; i++) begin
			slot_size[i] = 0; slot_hdl[i] = 0; slot_link[i] = 0;
			free_slots[i] = NS - 1 - i;
		end
		ring_head = 0; ring_tail = 0; ring_len = 0;
		free_len = NS; total_pkts = 0;
	endfunction

	function automatic sfq_pkg::result_t schedule_enqueue(sfq_pkg::in_item_t it);
		sfq_pkg::result_t r;
		int unsigned nf, f, c, s, left;
		bit drop;
		r = '0;
		nf = eff_flows();
		f = it.unclassified ? nf : it.flow_hash % nf;
		c = pkt_count[f];
		r.flow_index = sfq_pkg::FIDX_W'(f);
		if (ns2) begin
			left = total_lim > total_pkts ? total_lim - total_pkts : 0;
			drop = c >= (left >> 1) || (left < nf && c > share_r) || left == 0;
		end else begin
			drop = total_pkts >= total_lim || (total_lim - total_pkts < nf && c > share_r);
		end
		if (drop || free_len == 0) begin
			r.status = sfq_pkg::ST_DROP_LIMIT;
			return r;
		end
		if (c >= flow_lim) begin
			r.status = sfq_pkg::ST_DROP_FULL;
			return r;
		end
		if (!active[f]) begin
			active[f] = 1;
			if (!ns2) deficit[f] = eff_quantum();
			ring_push(f);
		end
		free_len--;
		s = free_slots[free_len] % NS;
		slot_size[s] = it.packet_size;
		slot_hdl[s] = it.packet_handle;
		if (c == 0) list_head[f] = s;
		else slot_link[list_tail[f]] = s;
		list_tail[f] = s;
		pkt_count[f] = c + 1;
		total_pkts++;
		r.status = sfq_pkg::ST_ACCEPTED;
		return r;
	endfunction

	// jump over whole rounds where no active flow could send
	function automatic void skip_idle_rounds();
		int q, k, kmin, f;
		q = eff_quantum();
		kmin = -1;
		for (int i = 0; i < ring_len; i++) begin
			f = ring[(ring_head + i) % NF];
			if (deficit[f] > 0) return;
			k = (q - deficit[f]) / q;
			if (kmin < 0 || k < kmin) kmin = k;
		end
		if (kmin > 1)
			for (int i = 0; i < ring_len; i++) begin
				f = ring[(ring_head + i) % NF];
				deficit[f] += (kmin - 1) * q;
			end
	endfunction

	function automatic sfq_pkg::result_t schedule_dequeue();
		sfq_pkg::result_t r;
		int unsigned f, s;
		r = '0;
		forever begin
			if (ring_len == 0) begin
				r.status = sfq_pkg::ST_EMPTY;
				return r;
			end
			if (!ns2) begin
				skip_idle_rounds();
				while (deficit[ring[ring_head]] <= 0) begin
					f = ring[ring_head];
					deficit[f] += eff_quantum();
					ring_pop();
					ring_push(f);
				end
			end
			f = ring[ring_head];
			if (pkt_count[f] == 0) begin
				active[f] = 0;
				ring_pop();
				continue;
			end
			s = list_head[f] % NS;
			r.out_size = 16'(slot_size[s]);
			r.out_handle = 16'(slot_hdl[s]);
			list_head[f] = slot_link[s];
			pkt_count[f]--;
			if (total_pkts > 0) total_pkts--;
			if (free_len < NS) begin
				free_slots[free_len] = s;
				free_len++;
			end
			if (ns2) begin
				ring_pop();
				if (pkt_count[f] == 0) active[f] = 0;
				else ring_push(f);
			end else begin
				deficit[f] -= int'(r.out_size);
			end
			r.status = sfq_pkg::ST_DEQUEUED;
			r.flow_index = sfq_pkg::FIDX_W'(f);
			return r;
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		sfq_pkg::result_t want;
		if (!arst_n) begin
			clear_state();
			exp_wr = 0;
			exp_rd = 0;
		end else begin
			if (result_valid) begin
				if (exp_wr == exp_rd) begin
					report_mismatch("unexpected word, status", result.status, -1);
				end else begin
					want = take_expected();
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
					if (result.flow_index !== want.flow_index)
						report_mismatch("flow_index", result.flow_index, want.flow_index);
					if (result.out_size !== want.out_size)
						report_mismatch("out_size", result.out_size, want.out_size);
					if (result.out_handle !== want.out_handle)
						report_mismatch("out_handle", result.out_handle, want.out_handle);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sfq_pkg::CFG_QUANTUM:     quantum_r = cfg_data;
					sfq_pkg::CFG_TOTAL_LIMIT: total_lim = cfg_data[sfq_pkg::CNT_W-1:0];
					sfq_pkg::CFG_FLOW_LIMIT:  flow_lim = cfg_data[sfq_pkg::CNT_W-1:0];
					sfq_pkg::CFG_FLOWS:       flows_r = cfg_data[sfq_pkg::CNT_W-1:0];
					sfq_pkg::CFG_FAIR_SHARE:  share_r = cfg_data[sfq_pkg::CNT_W-1:0];
					sfq_pkg::CFG_NS2_MODE:    ns2 = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (item.cmd == sfq_pkg::CMD_DEQ) store_expected(schedule_dequeue());
				else store_expected(schedule_enqueue(item));
			end
		end
	end
endmodule

[tb/testbench.sv]
// Top of the SFQ/DRR scheduler testbench: clock, reset, command and config
// stimulus, verdict. Depends on sfq_pkg, sfq_scoreboard and the scheduler RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 20000000;
	localparam int NPHASE = 7;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              start = 0;
	logic              busy;
	sfq_pkg::in_item_t item = '0;
	logic              result_valid;
	sfq_pkg::result_t  result;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;
	int                fail_count, pending_count;
	int                cycles = 0;

	sfq_pkg::cfg_t phase_cfg[NPHASE];
	int            phase_items[NPHASE];
	int            phase_enq_pct[NPHASE];

	sfq_drr_packet_scheduler_top dut (
		.clk, .arst_n, .start, .busy, .item, .result_valid, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	sfq_scoreboard u_scoreboard (
		.clk, .arst_n, .start, .busy, .item, .result_valid, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending_count
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic issue_command(sfq_pkg::in_item_t it);
		@(negedge clk);
		start <= 1;
		item <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		int n, r;
		r = $urandom_range(0, 99);
		n = r < 65 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
		if (n > 0) begin
			@(negedge clk);
			start <= 0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold commands until every result is in, then let the core settle
	task automatic wait_idle();
		@(negedge clk);
		start <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic load_config(sfq_pkg::cfg_t c);
		write_reg(sfq_pkg::CFG_QUANTUM, c.quantum);
		write_reg(sfq_pkg::CFG_TOTAL_LIMIT, 16'(c.total_limit));
		write_reg(sfq_pkg::CFG_FLOW_LIMIT, 16'(c.per_flow_limit));
		write_reg(sfq_pkg::CFG_FLOWS, 16'(c.flows_in_use));
		write_reg(sfq_pkg::CFG_FAIR_SHARE, 16'(c.fair_share));
		write_reg(sfq_pkg::CFG_NS2_MODE, 16'(c.ns2_mode));
	endtask

	function automatic sfq_pkg::in_item_t make_packet(logic [31:0] h, logic u,
			logic [15:0] sz, logic [15:0] hd);
		sfq_pkg::in_item_t it;
		it.cmd = sfq_pkg::CMD_ENQ;
		it.flow_hash = h;
		it.unclassified = u;
		it.packet_size = sz;
		it.packet_handle = hd;
		return it;
	endfunction

	function automatic sfq_pkg::in_item_t random_command(int enq_pct);
		sfq_pkg::in_item_t it;
		int r;
		it.flow_hash = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
		it.unclassified = $urandom_range(0, 9) == 0;
		r = $urandom_range(0, 99);
		it.packet_size = r < 3 ? 16'd0 : r < 13 ? 16'd1 : r < 23 ? 16'hFFFF :
			r < 40 ? 16'($urandom) : 16'($urandom_range(1, 1500));
		it.packet_handle = 16'($urandom);
		it.cmd = $urandom_range(0, 99) < enq_pct ? sfq_pkg::CMD_ENQ : sfq_pkg::CMD_DEQ;
		return it;
	endfunction

	initial begin
		sfq_pkg::in_item_t deq;
		deq = '0;
		deq.cmd = sfq_pkg::CMD_DEQ;
		// quantum, total, per-flow, flows, fair share, ns2
		phase_cfg[0] = '{16'd1500, 11'd1024, 11'd1024, 11'd1024, 11'd1, 1'b0};
		phase_cfg[1] = '{16'd256, 11'd40, 11'd6, 11'd4, 11'd3, 1'b0};
		phase_cfg[2] = '{16'hFFFF, 11'd30, 11'd8, 11'd3, 11'd2, 1'b1};
		phase_cfg[3] = '{16'd0, 11'd2047, 11'd2047, 11'd0, 11'd0, 1'b0};
		phase_cfg[4] = '{16'd300, 11'd1, 11'd1, 11'd2047, 11'd1024, 1'b0};
		phase_cfg[5] = '{16'd64, 11'd1024, 11'd1024, 11'd1024, 11'd1, 1'b1};
		phase_cfg[6] = '{16'd700, 11'd60, 11'd1, 11'd1, 11'd1024, 1'b0};
		phase_items = '{150, 140, 140, 1030, 90, 110, 80};
		phase_enq_pct = '{55, 55, 55, 100, 30, 40, 55};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: empty dequeue, field extremes, extra flow, drain
		issue_command(deq);
		issue_command(make_packet(32'h0, 1'b0, 16'd1, 16'h0000));
		issue_command(make_packet(32'hFFFFFFFF, 1'b0, 16'hFFFF, 16'hFFFF));
		issue_command(make_packet(32'h12345678, 1'b1, 16'd64, 16'hA5A5));
		issue_command(make_packet(32'h0, 1'b0, 16'd1500, 16'h5A5A));
		issue_command(make_packet(32'd1024, 1'b0, 16'd1501, 16'h0001));
		issue_command(make_packet(32'h0, 1'b1, 16'd2, 16'h8000));
		repeat (8) issue_command(deq);

		for (int p = 0; p < NPHASE; p++) begin
			if (p > 0) begin
				wait_idle();
				load_config(phase_cfg[p]);
			end
			for (int i = 0; i < phase_items[p]; i++) begin
				if (i == phase_items[p] / 2) wait_idle();
				issue_command(random_command(phase_enq_pct[p]));
				idle_gap();
			end
		end
		wait_idle();
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
